[src/casp_pkg.sv]
package casp_pkg;

    // Line buffer depth and the widths that follow from it
    localparam int MAX_WIDTH = 256;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 9;
    localparam int LEN_W     = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int THR_W     = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [DIM_W-1:0] GRID_WIDTH_RST     = DIM_W'(64);
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST    = DIM_W'(64);
    localparam logic [THR_W-1:0] WALL_THRESHOLD_RST = THR_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH     = 2'd0,
        CFG_GRID_HEIGHT    = 2'd1,
        CFG_WALL_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Window column outside the grid
    localparam logic [2:0] BORDER_COL = 3'b111;

    typedef struct packed {
        logic action;
        logic cell_is_wall;
    } t_in_item;

    typedef struct packed {
        logic new_is_wall;
        logic last_of_frame;
    } t_out_item;

endpackage

[src/cave_automaton_smoothing_pass_top.sv]
// Cave smoothing pass: one step of a 3x3 wall/floor cellular automaton.
// Input channel (i_in_valid / o_in_ready / i_in_data): one cell per item in
// raster order, grid_height rows of grid_width cells, then one row of
// grid_width padding items that flushes the last grid row.
// Output channel (o_out_valid / i_out_ready / o_out_data): smoothed cells in
// raster order, one row behind the input; last_of_frame marks the final one.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_wdata): write only, one cycle,
// index 0 grid_width, 1 grid_height, 2 wall_threshold. Write while idle.
// Throughput: one item per cycle, sustained while the receiver keeps up;
// the row end item yields two results, which a four-entry result queue
// absorbs while the next row's first item yields none. A result can be
// taken after the item completing its window: line buffer read, then queue.
// The line buffers share one 2-bit wide RAM read in the input stage, ahead of the
// window stage; a bypass covers a one-column grid reading its own write.
// Reset clears the counters, the window, the stage valid and the queue and
// loads the register defaults; the line RAM is not cleared, top-row reads
// are forced to border instead.
// When the receiver stalls, the queue fills and the window stage holds,
// and o_in_ready drops once fewer than two queue entries are free.
module cave_automaton_smoothing_pass_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  casp_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output casp_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [casp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [casp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int COL_W    = casp_pkg::COL_W;
    localparam int DIM_W    = casp_pkg::DIM_W;
    localparam int LEN_W    = casp_pkg::LEN_W;
    localparam int THR_W    = casp_pkg::THR_W;
    localparam int OQ_PTR_W = casp_pkg::OQ_PTR_W;

    // Configuration registers
    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [THR_W-1:0] r_wall_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= casp_pkg::GRID_WIDTH_RST;
            r_grid_height    <= casp_pkg::GRID_HEIGHT_RST;
            r_wall_threshold <= casp_pkg::WALL_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                casp_pkg::CFG_GRID_WIDTH:     r_grid_width     <= i_cfg_wdata[DIM_W-1:0];
                casp_pkg::CFG_GRID_HEIGHT:    r_grid_height    <= i_cfg_wdata[DIM_W-1:0];
                casp_pkg::CFG_WALL_THRESHOLD: r_wall_threshold <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least 1
    logic [LEN_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    always_comb begin
        if (r_grid_width == '0) begin
            width_eff = LEN_W'(1);
        end else if (LEN_W'(r_grid_width) > LEN_W'(casp_pkg::MAX_WIDTH)) begin
            width_eff = LEN_W'(casp_pkg::MAX_WIDTH);
        end else begin
            width_eff = LEN_W'(r_grid_width);
        end
        height_eff = (r_grid_height == '0) ? DIM_W'(1) : r_grid_height;
    end

    // ---------------------------------------------------------------
    // Input stage: position counters, line RAM read
    // ---------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic             in_accept;
    logic             row_end;
    logic             pad_row;
    logic             frame_end;
    logic             incoming;

    assign in_accept = i_in_valid && o_in_ready;
    assign row_end   = (LEN_W'(r_col) + LEN_W'(1)) >= width_eff;
    assign pad_row   = r_row >= height_eff;
    assign frame_end = pad_row && row_end;
    // Padding in a grid row reads as wall
    assign incoming  = i_in_data.action | i_in_data.cell_is_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Window stage
    // ---------------------------------------------------------------
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_top;       // row 0 or 1: upper line is border
    logic             r_s1_has_out;   // row >= 1
    logic             r_s1_pad;
    logic             r_s1_row_end;
    logic             r_s1_frame_end;
    logic             r_s1_first_col;
    logic             r_s1_second_col;
    logic             r_s1_inc;
    logic             r_byp;
    logic [1:0]       r_byp_data;

    logic             s1_fire;
    logic [1:0]       ram_q;
    logic [1:0]       line_q;         // bit0 upper, bit1 middle
    logic [1:0]       line_wdata;
    logic [2:0]       col_bits;
    logic [8:0]       r_window;
    logic [8:0]       n_window;

    casp_ram #(
        .WIDTH (2),
        .DEPTH (casp_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (line_wdata),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col        <= r_col;
            r_s1_top        <= r_row <= DIM_W'(1);
            r_s1_has_out    <= r_row != '0;
            r_s1_pad        <= pad_row;
            r_s1_row_end    <= row_end;
            r_s1_frame_end  <= frame_end;
            r_s1_first_col  <= r_col == '0;
            r_s1_second_col <= r_col == COL_W'(1);
            r_s1_inc        <= incoming;
            // Same column written this cycle: the RAM returns stale data
            r_byp           <= s1_fire && (r_s1_col == r_col);
            r_byp_data      <= line_wdata;
        end
    end

    assign line_q     = r_byp ? r_byp_data : ram_q;
    assign line_wdata = {r_s1_inc, line_q[1]};
    assign col_bits   = {r_s1_pad ? 1'b1 : r_s1_inc, line_q[1], r_s1_top ? 1'b1 : line_q[0]};
    assign n_window   = {col_bits, r_window[8:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (s1_fire) begin
            r_window <= n_window;
        end
    end

    function automatic logic [3:0] wall_count(
        input logic [2:0] left,
        input logic [2:0] centre,
        input logic [2:0] right
    );
        wall_count = 4'(left[0]) + 4'(left[1]) + 4'(left[2])
                   + 4'(right[0]) + 4'(right[1]) + 4'(right[2])
                   + 4'(centre[0]) + 4'(centre[2]);
    endfunction

    // Result for the cell one column back, and for the last cell at row end
    logic                res_a_valid;
    logic                res_b_valid;
    logic [2:0]          a_left;
    logic [2:0]          b_left;
    casp_pkg::t_out_item res_a;
    casp_pkg::t_out_item res_b;

    always_comb begin
        res_a_valid = r_s1_has_out && !r_s1_first_col;
        res_b_valid = r_s1_has_out && r_s1_row_end;
        a_left = r_s1_second_col ? casp_pkg::BORDER_COL : n_window[2:0];
        b_left = r_s1_first_col ? casp_pkg::BORDER_COL : n_window[5:3];
        res_a.new_is_wall   = wall_count(a_left, n_window[5:3], n_window[8:6])
                              > r_wall_threshold;
        res_a.last_of_frame = r_s1_frame_end && !res_b_valid;
        res_b.new_is_wall   = wall_count(b_left, n_window[8:6], casp_pkg::BORDER_COL)
                              > r_wall_threshold;
        res_b.last_of_frame = r_s1_frame_end;
    end

    // ---------------------------------------------------------------
    // Result queue: two pushes, one pop per cycle
    // ---------------------------------------------------------------
    casp_pkg::t_out_item r_oq [casp_pkg::OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wp;
    logic [OQ_PTR_W-1:0] r_oq_rp;
    logic [OQ_PTR_W:0]   r_oq_cnt;
    logic [OQ_PTR_W:0]   push_n;
    logic                pop;
    casp_pkg::t_out_item push_first;

    // Advance the window stage only with room for both results
    assign s1_fire    = r_s1_valid && (r_oq_cnt <= (OQ_PTR_W+1)'(casp_pkg::OQ_DEPTH - 2));
    assign o_in_ready = !r_s1_valid || s1_fire;

    assign push_n     = s1_fire ? (OQ_PTR_W+1)'(res_a_valid) + (OQ_PTR_W+1)'(res_b_valid)
                                : '0;
    assign push_first = res_a_valid ? res_a : res_b;
    assign pop        = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (res_a_valid || res_b_valid) begin
                r_oq[r_oq_wp] <= push_first;
            end
            if (res_a_valid && res_b_valid) begin
                r_oq[r_oq_wp + OQ_PTR_W'(1)] <= res_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_oq_wp  <= r_oq_wp + push_n[OQ_PTR_W-1:0];
            r_oq_rp  <= r_oq_rp + OQ_PTR_W'(pop);
            r_oq_cnt <= r_oq_cnt + push_n - (OQ_PTR_W+1)'(pop);
        end
    end

    assign o_out_valid = r_oq_cnt != '0;
    assign o_out_data  = r_oq[r_oq_rp];

endmodule

[src/casp_ram.sv]
module casp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/casp_checker.sv]
module casp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input casp_pkg::t_out_item o_out_data
);

    // Reset empties the block and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // Input backpressure comes only from pending results
    a_stall_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A result taken during a stall leaves the input open or more results waiting
    a_drain_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && i_out_ready |=> o_in_ready || o_out_valid)
        else $error("input stuck closed with queue drained");

endmodule

bind cave_automaton_smoothing_pass_top casp_checker u_casp_checker (.*);
